// ----- rtl/core/isort_pkg.sv -----
// ----------------------------------------------------------------------------
// isort_pkg : shared types and constants of the insertion sorter
// Key width, default store depth and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int ISORT_KEY_W = 64;
    localparam int ISORT_DEPTH = 8;

    typedef logic [ISORT_KEY_W-1:0] key_t;

    // broadcast to every cell each cycle
    typedef struct packed {
        logic insert;   // place the broadcast key into the row
        logic pop;      // shift the row down by one (cell 0 leaves)
    } cell_ctrl_t;

endpackage

// ----- rtl/core/insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter : stable insertion sort of short text keys
// A row of compare-and-shift cells keeps the stored keys in ascending order;
// the word flagged last starts a run that streams the sorted set out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata        | tlast      | tuser
//  s_*     | in  | key_text     | last_key   | -
//  m_*     | out | sorted_key   | end_of_run | overflowed
//
//  Fill: one key accepted per cycle; every cell compares in parallel.
//  Run: one sorted key per cycle from cell 0 while m_tready is high, the row
//  shifting down on each pop; s_tready is low for the whole run.
//  Keys arriving with the row full are dropped and flagged on the run.
//  Reset empties the row at once; m_tready low simply holds the run.
// ----------------------------------------------------------------------------
module insertion_sorter #(
    parameter int SORT_DEPTH = isort_pkg::ISORT_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  isort_pkg::key_t        s_tdata,    // [63:0] key_text
    input  logic                   s_tlast,    // last_key
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output isort_pkg::key_t        m_tdata,    // [63:0] sorted_key
    output logic                   m_tlast,    // end_of_run
    output logic                   m_tuser     // [0] overflowed
);
    import isort_pkg::*;

    key_t                  cell_key [SORT_DEPTH];
    logic [SORT_DEPTH-1:0] cell_valid;
    logic [SORT_DEPTH-1:0] cell_greater;
    cell_ctrl_t            ctrl;

    logic draining_reg;
    logic draining_next;
    logic dropped_reg;
    logic dropped_next;
    logic in_accept;
    logic out_accept;
    logic full;

    assign full       = cell_valid[SORT_DEPTH-1];
    assign s_tready   = !draining_reg;
    assign in_accept  = s_tvalid && s_tready;
    assign m_tvalid   = draining_reg;
    assign out_accept = m_tvalid && m_tready;

    assign ctrl.insert = in_accept && !full;
    assign ctrl.pop    = out_accept;

    genvar gi;
    generate
        for (gi = 0; gi < SORT_DEPTH; gi++)
        begin : g_cell
            key_t prev_key;
            logic prev_valid;
            logic prev_greater;
            key_t next_key;
            logic next_valid;

            if (gi == 0)
            begin : g_first
                assign prev_key     = s_tdata;
                assign prev_valid   = 1'b1;
                assign prev_greater = 1'b0;
            end
            else
            begin : g_mid
                assign prev_key     = cell_key[gi-1];
                assign prev_valid   = cell_valid[gi-1];
                assign prev_greater = cell_greater[gi-1];
            end

            if (gi == SORT_DEPTH-1)
            begin : g_top
                assign next_key   = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_low
                assign next_key   = cell_key[gi+1];
                assign next_valid = cell_valid[gi+1];
            end

            isort_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .new_key      (s_tdata),
                .prev_key     (prev_key),
                .prev_valid   (prev_valid),
                .prev_greater (prev_greater),
                .next_key     (next_key),
                .next_valid   (next_valid),
                .key          (cell_key[gi]),
                .valid        (cell_valid[gi]),
                .greater      (cell_greater[gi])
            );
        end
    endgenerate

    assign m_tdata = cell_key[0];
    assign m_tlast = !cell_valid[1];
    assign m_tuser = dropped_reg;

    always_comb
    begin
        draining_next = draining_reg;
        dropped_next  = dropped_reg;
        priority if (out_accept && m_tlast)
        begin
            draining_next = 1'b0;
            dropped_next  = 1'b0;
        end
        else if (in_accept)
        begin
            dropped_next  = dropped_reg || full;
            draining_next = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            dropped_reg  <= dropped_next;
        end
    end

    // a run never shows an empty cell 0
    a_run_has_key : assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> cell_valid[0])
        else $error("run active with empty row");

    // occupied cells always form a prefix of the row
    a_valid_prefix : assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("gap in occupied cells");

    // the final word of a run ends it and leaves the row empty
    a_run_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && m_tlast) |=> (!draining_reg && cell_valid == '0 && !dropped_reg))
        else $error("run did not close cleanly");

    // a last key always starts a run
    a_last_starts : assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tlast) |=> draining_reg)
        else $error("last key did not start a run");

endmodule

// ----- rtl/core/isort_cell.sv -----
// ----------------------------------------------------------------------------
// isort_cell : one slot of the sorting row
// Holds one key and its valid bit; on insert it either keeps its key, takes
// the broadcast key or takes its lower neighbour's key; on pop it takes its
// upper neighbour's key.
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  isort_pkg::cell_ctrl_t  ctrl,
    input  isort_pkg::key_t        new_key,
    input  isort_pkg::key_t        prev_key,
    input  logic                   prev_valid,
    input  logic                   prev_greater,
    input  isort_pkg::key_t        next_key,
    input  logic                   next_valid,
    output isort_pkg::key_t        key,
    output logic                   valid,
    output logic                   greater
);
    import isort_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;
    logic take;

    // strictly greater only, so equal keys keep arrival order
    assign greater = valid_reg && (new_key < key_reg);
    // first empty slot also takes part in an insert
    assign take    = greater || (!valid_reg && prev_valid);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        priority if (ctrl.pop)
        begin
            key_next   = next_key;
            valid_next = next_valid;
        end
        else if (ctrl.insert && take)
        begin
            key_next   = prev_greater ? prev_key : new_key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

// ----- tb/insertion_sorter_tb.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter_tb : self-checking bench for the insertion sorter
// Streams sets of text keys into the sorter with bursty input and a stalling
// output side. A scoreboard keeps its own sorted row, predicts every sorted
// word (end-of-run and overflow flags included) and checks the output stream.
// ----------------------------------------------------------------------------
module insertion_sorter_tb;

    import isort_pkg::*;

    localparam int DEPTH       = ISORT_DEPTH;
    localparam int RANDOM_KEYS = 88;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 3 * DEPTH + 20;

    typedef struct {
        key_t key;
        bit   run_end;
        bit   ovf;
    } sorted_word_t;

    class sort_scoreboard;
        key_t         row [DEPTH];
        int unsigned  held;
        bit           dropped;
        sorted_word_t pending [$];
        int unsigned  fail_count;

        function new();
            held       = 0;
            dropped    = 0;
            fail_count = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fail_count++;
        endtask

        // stable insert: a new key only passes stored keys strictly greater
        function void insert_key(key_t k, bit last);
            int           pos;
            int           i;
            sorted_word_t w;
            if (held < DEPTH)
            begin
                pos = held;
                while (pos > 0 && k < row[pos-1])
                begin
                    row[pos] = row[pos-1];
                    pos--;
                end
                row[pos] = k;
                held++;
            end
            else
                dropped = 1'b1;
            if (last)
            begin
                for (i = 0; i < held; i++)
                begin
                    w.key     = row[i];
                    w.run_end = (i == held - 1);
                    w.ovf     = dropped;
                    pending.push_back(w);
                end
                held    = 0;
                dropped = 1'b0;
            end
        endfunction

        task check_sorted(logic [ISORT_KEY_W-1:0] k, logic last, logic ovf);
            sorted_word_t w;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected word key=%h last=%b ovf=%b",
                                 k, last, ovf));
                return;
            end
            w = pending.pop_front();
            if (k !== w.key)
                report($sformatf("key %h, predicted %h", k, w.key));
            if (last !== w.run_end)
                report($sformatf("end_of_run %b, predicted %b (key %h)",
                                 last, w.run_end, w.key));
            if (ovf !== w.ovf)
                report($sformatf("overflowed %b, predicted %b (key %h)",
                                 ovf, w.ovf, w.key));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    key_t s_tdata;      // [63:0] key_text
    logic s_tlast;      // last_key
    logic m_tvalid;
    logic m_tready;
    key_t m_tdata;      // [63:0] sorted_key
    logic m_tlast;      // end_of_run
    logic m_tuser;      // [0] overflowed

    sort_scoreboard sb;
    int unsigned    cycle_count;
    int unsigned    burst_left;
    int unsigned    rx_tick;
    int unsigned    rx_mode;

    insertion_sorter #(.SORT_DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: switches between four stall modes, picked at random
    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_tick % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready = 1'b1;
            1: m_tready = (rx_tick % 4 != 0);
            2: m_tready = 1'($urandom_range(0, 1));
            default: m_tready = (rx_tick % 16 >= 12);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_sorted(m_tdata, m_tlast, m_tuser);
    end

    task automatic idle(int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    // bursts of random length; now and then a long stretch with no gaps
    task automatic pace();
        if (burst_left == 0)
        begin
            idle($urandom_range(1, 5));
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    task automatic send_key(key_t k, bit last);
        pace();
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = k;
        s_tlast  = last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.insert_key(k, last);
    endtask

    task automatic send_set(key_t keys [$]);
        int i;
        for (i = 0; i < keys.size(); i++)
            send_key(keys[i], i == keys.size() - 1);
    endtask

    // short text from a small alphabet, so prefixes and repeats are common
    function automatic key_t text_key();
        int   len;
        int   i;
        key_t k;
        len = $urandom_range(0, 8);
        k   = '0;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                k[63-8*i -: 8] = 8'($urandom_range(0, 255));
            else
                k[63-8*i -: 8] = 8'($urandom_range(97, 100));
        end
        return k;
    endfunction

    initial
    begin
        key_t        keys [$];
        int unsigned sent;
        int unsigned set_size;
        int unsigned j;

        sb          = new();
        cycle_count = 0;
        burst_left  = 0;
        rx_tick     = 0;
        rx_mode     = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // a set of one key
        keys = '{64'hFFFF_FFFF_FFFF_FFFF};
        send_set(keys);
        // extremes, the sign bit boundary, prefixes and an embedded zero byte
        keys = '{64'h6162_6300_0000_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h6162_0000_0000_0000, 64'h6100_6200_0000_0000};
        send_set(keys);
        // equal keys
        keys = '{64'h6361_7400_0000_0000, 64'h6361_7400_0000_0000,
                 64'h616E_7400_0000_0000, 64'h6361_7400_0000_0000};
        send_set(keys);
        // row full: the last two keys, the flagged one among them, are dropped
        keys.delete();
        for (j = 0; j < 10; j++)
            keys.push_back({$urandom, $urandom});
        send_set(keys);

        sent = 0;
        while (sent < RANDOM_KEYS)
        begin
            set_size = ($urandom_range(0, 5) == 0) ? $urandom_range(DEPTH + 1, DEPTH + 4)
                                                   : $urandom_range(1, DEPTH);
            keys.delete();
            for (j = 0; j < set_size; j++)
            begin
                case ($urandom_range(0, 3))
                    0, 1: keys.push_back(text_key());
                    2: keys.push_back({$urandom, $urandom});
                    default:
                        if (j > 0)
                            keys.push_back(keys[$urandom_range(0, j - 1)]);
                        else
                            keys.push_back(text_key());
                endcase
            end
            send_set(keys);
            sent += set_size;
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (sb.fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
